FILE: rtl/core/tournament_branch_predictor_defines.svh
// assertion macros for the tournament branch predictor
`ifndef TOURNAMENT_BRANCH_PREDICTOR_DEFINES_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define TBP_ASSERT(label, clk_, rst_, prop_) \
  label: assert property (@(posedge clk_) disable iff (rst_) prop_) \
    else $error("tbp assertion failed");
`define TBP_ASSERT_ALWAYS(label, clk_, prop_) \
  label: assert property (@(posedge clk_) prop_) \
    else $error("tbp assertion failed");
`else
`define TBP_ASSERT(label, clk_, rst_, prop_)
`define TBP_ASSERT_ALWAYS(label, clk_, prop_)
`endif

`endif

FILE: rtl/core/tbp_pkg.sv
package tbp_pkg;

  localparam int ADDR_W = 32;
  localparam int OUT_CNT_W = 32;
  localparam int HIST_W = 11;
  localparam int CFG_W = 4;
  localparam int CTR_W = 2;

  localparam logic [CFG_W-1:0] HIST_LEN_MAX = 4'd11;
  localparam logic [CTR_W-1:0] CTR_STRONG_TAKEN = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MIN = 2'd0;
  localparam logic [CTR_W-1:0] CHO_STRONG_GSHARE = 2'd0;

  typedef struct packed {
    logic [ADDR_W-1:0] branch_address;
    logic              taken;
  } branch_t;

  typedef struct packed {
    logic                 predicted_taken;
    logic                 prediction_correct;
    logic [OUT_CNT_W-1:0] correct_count;
    logic [OUT_CNT_W-1:0] branch_count;
  } result_t;

  // bimodal and chooser share the address index
  typedef struct packed {
    logic [CTR_W-1:0] chooser;
    logic [CTR_W-1:0] bimodal;
  } bc_entry_t;

  function automatic logic [CTR_W-1:0] sat_train(input logic [CTR_W-1:0] c, input logic up);
    logic [CTR_W-1:0] r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/tournament_branch_predictor.sv
// tournament branch predictor: bimodal and gshare tables with a per-address chooser
//
// input channel: branch_valid / branch_stall carry one resolved branch item
// (address and outcome). output channel: result_valid / result_stall carry
// one result item per branch: the tournament prediction made before training,
// whether it was right, and saturating counts of correct predictions and
// branches including this one. cfg_write / cfg_data set the history length
// (values above 11 act as 11); write it only while the block is idle.
// an accepted branch passes the read stage, then the result register.
// throughput: one branch per cycle while the result is not stalled; tables
// are synchronous rams read on accept and written back as the branch leaves
// the read stage, with the last write forwarded. after rst the tables are
// swept to their initial values, one entry per cycle through every index,
// with branch_stall high; configuration writes are taken during the sweep.
// when result_stall is high the result item holds, and branch_stall rises
// once the in-flight stage is also full; no item is lost or repeated.
`include "tournament_branch_predictor_defines.svh"

module tournament_branch_predictor #(
  parameter int TABLE_ENTRIES = 2048,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      branch_valid,
  output logic                      branch_stall,
  input  tbp_pkg::branch_t          branch,
  output logic                      result_valid,
  input  logic                      result_stall,
  output tbp_pkg::result_t          result,
  input  logic                      cfg_write,
  input  logic [tbp_pkg::CFG_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int BC_W = $bits(tbp_pkg::bc_entry_t);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  logic [tbp_pkg::CFG_W-1:0]  hist_len;
  logic [tbp_pkg::CFG_W-1:0]  hist_len_eff;
  logic [tbp_pkg::HIST_W-1:0] hist;
  logic [tbp_pkg::HIST_W-1:0] hist_next;
  logic [tbp_pkg::HIST_W-1:0] hmask;
  logic [tbp_pkg::HIST_W+IDX_W-1:0] hist_wide;

  logic             clearing;
  logic [IDX_W-1:0] clr_idx;

  logic             accept;
  logic             advance;
  logic [IDX_W-1:0] in_bi;
  logic [IDX_W-1:0] in_gi;

  logic             p1_valid;
  logic [IDX_W-1:0] p1_bi;
  logic [IDX_W-1:0] p1_gi;
  logic             p1_taken;

  tbp_pkg::bc_entry_t           bc_rd;
  logic [tbp_pkg::CTR_W-1:0]    gs_rd;
  tbp_pkg::bc_entry_t           bc_cur;
  logic [tbp_pkg::CTR_W-1:0]    gs_cur;
  tbp_pkg::bc_entry_t           bc_new;
  logic [tbp_pkg::CTR_W-1:0]    gs_new;

  logic                         lw_valid;
  logic [IDX_W-1:0]             lw_bi;
  logic [IDX_W-1:0]             lw_gi;
  tbp_pkg::bc_entry_t           lw_bc;
  logic [tbp_pkg::CTR_W-1:0]    lw_gs;

  logic                         bc_we;
  logic [IDX_W-1:0]             bc_waddr;
  tbp_pkg::bc_entry_t           bc_wdata;
  logic [IDX_W-1:0]             gs_waddr;
  logic [tbp_pkg::CTR_W-1:0]    gs_wdata;

  logic bim_pred;
  logic gsh_pred;
  logic bim_ok;
  logic gsh_ok;
  logic pred;
  logic ok;

  logic [COUNT_WIDTH-1:0] correct_total;
  logic [COUNT_WIDTH-1:0] branch_total;
  logic [COUNT_WIDTH-1:0] correct_total_next;
  logic [COUNT_WIDTH-1:0] branch_total_next;
  logic [tbp_pkg::OUT_CNT_W+COUNT_WIDTH-1:0] correct_wide;
  logic [tbp_pkg::OUT_CNT_W+COUNT_WIDTH-1:0] branch_wide;

  assign advance      = p1_valid && (!result_valid || !result_stall);
  assign branch_stall = clearing || (p1_valid && !advance);
  assign accept       = branch_valid && !branch_stall;

  // history and index
  always_comb begin
    hist_len_eff = (hist_len > tbp_pkg::HIST_LEN_MAX) ? tbp_pkg::HIST_LEN_MAX : hist_len;
    for (int i = 0; i < tbp_pkg::HIST_W; i++) begin
      hmask[i] = (tbp_pkg::CFG_W'(i) < hist_len_eff);
    end
  end

  assign hist_next = {hist[tbp_pkg::HIST_W-2:0], branch.taken} & hmask;
  assign hist_wide = {{IDX_W{1'b0}}, hist};
  assign in_bi     = branch.branch_address[IDX_W-1:0];
  assign in_gi     = branch.branch_address[IDX_W-1:0] ^ hist_wide[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_len <= tbp_pkg::HIST_LEN_MAX;
    end else if (cfg_write) begin
      hist_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (accept) begin
      hist <= hist_next;
    end
  end

  // table sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + IDX_W'(1);
      if (clr_idx == IDX_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (advance) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_bi    <= in_bi;
      p1_gi    <= in_gi;
      p1_taken <= branch.taken;
    end
  end

  tbp_ram #(
    .WIDTH (BC_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_bc_ram (
    .clk   (clk),
    .we    (bc_we),
    .waddr (bc_waddr),
    .wdata (bc_wdata),
    .re    (accept),
    .raddr (in_bi),
    .rdata (bc_rd)
  );

  tbp_ram #(
    .WIDTH (tbp_pkg::CTR_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_gs_ram (
    .clk   (clk),
    .we    (bc_we),
    .waddr (gs_waddr),
    .wdata (gs_wdata),
    .re    (accept),
    .raddr (in_gi),
    .rdata (gs_rd)
  );

  // forward the most recent write over the ram read
  always_comb begin
    bc_cur = (lw_valid && (lw_bi == p1_bi)) ? lw_bc : bc_rd;
    gs_cur = (lw_valid && (lw_gi == p1_gi)) ? lw_gs : gs_rd;

    bim_pred = bc_cur.bimodal[1];
    gsh_pred = gs_cur[1];
    bim_ok   = (bim_pred == p1_taken);
    gsh_ok   = (gsh_pred == p1_taken);
    pred     = bc_cur.chooser[1] ? bim_pred : gsh_pred;
    ok       = (pred == p1_taken);

    bc_new.bimodal = tbp_pkg::sat_train(bc_cur.bimodal, p1_taken);
    bc_new.chooser = (bim_ok != gsh_ok) ? tbp_pkg::sat_train(bc_cur.chooser, bim_ok)
                                        : bc_cur.chooser;
    gs_new         = tbp_pkg::sat_train(gs_cur, p1_taken);
  end

  always_comb begin
    bc_we = clearing || advance;
    if (clearing) begin
      bc_waddr         = clr_idx;
      gs_waddr         = clr_idx;
      bc_wdata.chooser = tbp_pkg::CHO_STRONG_GSHARE;
      bc_wdata.bimodal = tbp_pkg::CTR_STRONG_TAKEN;
      gs_wdata         = tbp_pkg::CTR_STRONG_TAKEN;
    end else begin
      bc_waddr = p1_bi;
      gs_waddr = p1_gi;
      bc_wdata = bc_new;
      gs_wdata = gs_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (bc_we) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (bc_we) begin
      lw_bi <= bc_waddr;
      lw_gi <= gs_waddr;
      lw_bc <= bc_wdata;
      lw_gs <= gs_wdata;
    end
  end

  // saturating counts
  always_comb begin
    branch_total_next  = (&branch_total) ? branch_total : branch_total + COUNT_WIDTH'(1);
    correct_total_next = correct_total;
    if (ok && !(&correct_total)) begin
      correct_total_next = correct_total + COUNT_WIDTH'(1);
    end
    correct_wide = {{tbp_pkg::OUT_CNT_W{1'b0}}, correct_total_next};
    branch_wide  = {{tbp_pkg::OUT_CNT_W{1'b0}}, branch_total_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      correct_total <= '0;
      branch_total  <= '0;
    end else if (advance) begin
      correct_total <= correct_total_next;
      branch_total  <= branch_total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.predicted_taken    <= pred;
      result.prediction_correct <= ok;
      result.correct_count      <= correct_wide[tbp_pkg::OUT_CNT_W-1:0];
      result.branch_count       <= branch_wide[tbp_pkg::OUT_CNT_W-1:0];
    end
  end

  `TBP_ASSERT(a_accept_fills_stage, clk, rst, accept |=> p1_valid)
  `TBP_ASSERT(a_advance_gives_result, clk, rst, advance |=> result_valid)
  `TBP_ASSERT(a_sweep_wraps, clk, rst, $fell(clearing) |-> (clr_idx == '0))
  `TBP_ASSERT(a_counts_ordered, clk, rst,
              result_valid |-> (result.correct_count <= result.branch_count))

endmodule

FILE: rtl/core/tbp_ram.sv
module tbp_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
